// File: src/vrpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrpq_pkg
// Shared types and constants of the vote-ranked priority queue.
// ----------------------------------------------------------------------------
package vrpq_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_UP   = 2'd2,
        OP_DOWN = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } state_t;

    // A candidate that travels down the cell chain.
    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   idx;
        logic signed [16:0] score;
        logic [15:0]        age_dist;
        logic [15:0]        id;
        logic [15:0]        up;
        logic [15:0]        down;
    } cand_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic             clr_en;
        logic             inc_up;
        logic             inc_down;
        logic             scan;
        logic             by_id;
        logic [15:0]      key_id;
        logic [15:0]      next_age;
        logic [15:0]      id;
        logic [15:0]      up;
        logic [15:0]      down;
    } cmd_t;

endpackage
`default_nettype wire

// File: src/vrpq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrpq_cell
// One queue slot; compares itself against the incoming candidate and passes
// the winner to the next cell on each cycle of a scan.
// ----------------------------------------------------------------------------
module vrpq_cell
    import vrpq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] my_idx,
    input  wire cmd_t             cmd,
    input  wire logic             hit_sel,
    input  wire cand_t            cand_in,
    output cand_t                 cand_out,
    output logic                  free
);

    logic               valid_reg;
    logic [15:0]        id_reg;
    logic [15:0]        up_reg;
    logic [15:0]        down_reg;
    logic [15:0]        age_reg;
    logic [15:0]        age_dist;
    logic signed [16:0] score;
    logic               elig;
    logic               better;

    assign free     = ~valid_reg;
    assign age_dist = cmd.next_age - age_reg;
    assign score    = $signed({1'b0, up_reg}) - $signed({1'b0, down_reg});
    assign elig     = valid_reg && (!cmd.by_id || id_reg == cmd.key_id);

    always_comb
    begin
        better = 1'b0;
        if (elig)
        begin
            if (!cand_in.found)
                better = 1'b1;
            else if (cmd.by_id)
                better = age_dist > cand_in.age_dist;
            else
                better = (score > cand_in.score) ||
                         (score == cand_in.score && age_dist > cand_in.age_dist);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_out <= '0;
        end
        else if (cmd.scan)
        begin
            if (better)
                cand_out <= '{found: 1'b1, idx: my_idx, score: score, age_dist: age_dist,
                              id: id_reg, up: up_reg, down: down_reg};
            else
                cand_out <= cand_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd.wr_en && cmd.wr_idx == my_idx)
            valid_reg <= 1'b1;
        else if (cmd.clr_en && hit_sel)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && cmd.wr_idx == my_idx)
        begin
            id_reg   <= cmd.id;
            up_reg   <= cmd.up;
            down_reg <= cmd.down;
            age_reg  <= cmd.next_age;
        end
        else if (hit_sel && cmd.inc_up && up_reg != 16'hFFFF)
            up_reg <= up_reg + 16'd1;
        else if (hit_sel && cmd.inc_down && down_reg != 16'hFFFF)
            down_reg <= down_reg + 16'd1;
    end

endmodule
`default_nettype wire

// File: src/vote_ranked_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vote_ranked_priority_queue
// Priority queue of CAPACITY entries ranked by up minus down votes.
// ----------------------------------------------------------------------------
// Dequeue returns the entry with the highest up minus down score, the oldest
// one on ties. The chain of slot cells hands the best candidate one cell per
// cycle, and every request, enqueue included, walks the whole chain before the
// slot is updated and the result is registered. One request is in progress at a
// time; the result register holds until taken, and the next request is accepted
// only after the previous result has been taken.
module vote_ranked_priority_queue
    import vrpq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [15:0] entry_id,
    input  wire logic [15:0] init_up,
    input  wire logic [15:0] init_down,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [15:0]      out_id,
    output logic [15:0]      out_up,
    output logic [15:0]      out_down
);

    state_t             state_reg, state_next;
    logic [IDX_W:0]     step_reg, step_next;
    logic [1:0]         op_reg;
    logic [15:0]        id_reg, up_reg, down_reg;
    logic [15:0]        age_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic               free_any_reg;
    cmd_t               cmd;
    cand_t              chain [CAPACITY+1];
    logic [CAPACITY-1:0] free_vec;
    logic [CAPACITY-1:0] hit_vec;
    logic               accept, finish;
    logic [IDX_W-1:0]   fi;
    logic               fa;

    assign accept = in_valid && !in_stall;
    assign chain[0] = '0;

    always_comb
    begin
        fi = '0;
        fa = 1'b0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (free_vec[i])
            begin
                fi = IDX_W'(i);
                fa = 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
            hit_vec[i] = chain[CAPACITY].found && chain[CAPACITY].idx == IDX_W'(i);
    end

    assign finish = (state_reg == S_SCAN) && (step_reg == (IDX_W+1)'(CAPACITY));

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                step_next = '0;
                if (accept)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                step_next = step_reg + 1'b1;
                if (finish)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.scan     = (state_reg == S_SCAN) && !finish;
        cmd.by_id    = (op_reg != OP_DEQ);
        cmd.key_id   = id_reg;
        cmd.next_age = age_reg;
        cmd.id       = id_reg;
        cmd.up       = up_reg;
        cmd.down     = down_reg;
        cmd.wr_idx   = free_idx_reg;
        if (finish)
        begin
            unique case (op_t'(op_reg))
                OP_ENQ:  cmd.wr_en    = free_any_reg;
                OP_DEQ:  cmd.clr_en   = 1'b1;
                OP_UP:   cmd.inc_up   = 1'b1;
                OP_DOWN: cmd.inc_down = 1'b1;
                default: cmd.wr_en    = 1'b0;
            endcase
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        vrpq_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .my_idx   (IDX_W'(g)),
            .cmd      (cmd),
            .hit_sel  (hit_vec[g]),
            .cand_in  (chain[g]),
            .cand_out (chain[g+1]),
            .free     (free_vec[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            count_reg <= '0;
            age_reg   <= '0;
            out_valid <= 1'b0;
            status    <= ST_OK;
            out_id    <= '0;
            out_up    <= '0;
            out_down  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (out_valid && !out_stall)
                out_valid <= 1'b0;
            if (finish)
            begin
                out_valid <= 1'b1;
                status    <= ST_OK;
                out_id    <= '0;
                out_up    <= '0;
                out_down  <= '0;
                unique case (op_t'(op_reg))
                    OP_ENQ:
                    begin
                        if (free_any_reg)
                        begin
                            age_reg   <= age_reg + 16'd1;
                            count_reg <= count_reg + 1'b1;
                        end
                        else
                            status <= ST_FULL;
                    end
                    OP_DEQ:
                    begin
                        if (chain[CAPACITY].found)
                        begin
                            out_id    <= chain[CAPACITY].id;
                            out_up    <= chain[CAPACITY].up;
                            out_down  <= chain[CAPACITY].down;
                            count_reg <= count_reg - 1'b1;
                        end
                        else
                            status <= ST_EMPTY;
                    end
                    default:
                    begin
                        if (!chain[CAPACITY].found)
                            status <= ST_NOTFOUND;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= op;
            id_reg       <= entry_id;
            up_reg       <= init_up;
            down_reg     <= init_down;
            free_idx_reg <= fi;
            free_any_reg <= fa;
        end
    end

    assign in_stall = (state_reg != S_IDLE) || out_valid;

endmodule
`default_nettype wire

// File: src/vrpq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrpq_checker
// Port-level checks on the vote-ranked priority queue.
// ----------------------------------------------------------------------------
module vrpq_checker
    import vrpq_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [1:0]  status,
    input wire logic [15:0] out_id,
    input wire logic [15:0] out_up,
    input wire logic [15:0] out_down
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_id))
        else $error("Stalled result changed.");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("Request accepted while a result is pending.");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> out_id == 16'd0 && out_up == 16'd0 &&
        out_down == 16'd0)
        else $error("Failed request returned nonzero fields.");

    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid)
        else $error("Result appeared without processing time.");

endmodule

bind vote_ranked_priority_queue vrpq_checker u_vrpq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .out_id    (out_id),
    .out_up    (out_up),
    .out_down  (out_down)
);
`default_nettype wire

// File: sim/tb_vote_ranked_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vote_ranked_priority_queue
// Self-checking testbench for the vote-ranked priority queue.
// A directed table covers the empty and full cases, score extremes, vote
// saturation and unknown ids; random requests follow, mostly enqueues and
// votes on live ids, and each result is compared with a behavioral queue.
// ----------------------------------------------------------------------------
module tb_vote_ranked_priority_queue;
    import vrpq_pkg::*;

    localparam int LIMIT = 2000000;

    typedef struct packed {
        op_t         op;
        logic [15:0] id;
        logic [15:0] up;
        logic [15:0] down;
    } req_t;

    typedef struct packed {
        status_t     st;
        logic [15:0] id;
        logic [15:0] up;
        logic [15:0] down;
    } resp_t;

    typedef struct {
        req_t  rq;
        logic  fixed;
        resp_t rs;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  op;
    logic [15:0] entry_id;
    logic [15:0] init_up;
    logic [15:0] init_down;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [15:0] out_up;
    logic [15:0] out_down;

    logic        q_live [CAPACITY];
    logic [15:0] q_id [CAPACITY];
    logic [15:0] q_up [CAPACITY];
    logic [15:0] q_down [CAPACITY];
    logic [15:0] q_stamp [CAPACITY];
    int          q_count;
    logic [15:0] q_next_stamp;

    resp_t       pending_results [$];
    int          errors;
    int          cycles;
    int          accepted;
    int          checked;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic        hold_off;
    row_t        rows [$];

    vote_ranked_priority_queue DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .entry_id(entry_id), .init_up(init_up), .init_down(init_down),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .out_id(out_id), .out_up(out_up), .out_down(out_down)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic resp_t queue_apply(req_t rq);
        resp_t       r;
        int          k;
        logic [15:0] dk;
        logic [15:0] di;
        int          sk;
        int          si;
        r = '{st: ST_OK, id: 16'd0, up: 16'd0, down: 16'd0};
        k = -1;
        case (rq.op)
            OP_ENQ:
            begin
                for (int i = 0; i < CAPACITY; i++)
                    if (k < 0 && !q_live[i])
                        k = i;
                if (k < 0)
                    r.st = ST_FULL;
                else
                begin
                    q_live[k] = 1'b1;
                    q_id[k] = rq.id;
                    q_up[k] = rq.up;
                    q_down[k] = rq.down;
                    q_stamp[k] = q_next_stamp;
                    q_next_stamp = q_next_stamp + 16'd1;
                    q_count++;
                end
            end
            OP_DEQ:
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (!q_live[i])
                        continue;
                    if (k < 0)
                        k = i;
                    else
                    begin
                        si = int'(q_up[i]) - int'(q_down[i]);
                        sk = int'(q_up[k]) - int'(q_down[k]);
                        di = q_next_stamp - q_stamp[i];
                        dk = q_next_stamp - q_stamp[k];
                        if (si > sk || (si == sk && di > dk))
                            k = i;
                    end
                end
                if (k < 0)
                    r.st = ST_EMPTY;
                else
                begin
                    r.id = q_id[k];
                    r.up = q_up[k];
                    r.down = q_down[k];
                    q_live[k] = 1'b0;
                    q_count--;
                end
            end
            default:
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (!q_live[i] || q_id[i] != rq.id)
                        continue;
                    di = q_next_stamp - q_stamp[i];
                    dk = (k < 0) ? 16'd0 : q_next_stamp - q_stamp[k];
                    if (k < 0 || di > dk)
                        k = i;
                end
                if (k < 0)
                    r.st = ST_NOTFOUND;
                else if (rq.op == OP_UP && q_up[k] != 16'hFFFF)
                    q_up[k] = q_up[k] + 16'd1;
                else if (rq.op == OP_DOWN && q_down[k] != 16'hFFFF)
                    q_down[k] = q_down[k] + 16'd1;
            end
        endcase
        return r;
    endfunction

    task automatic send_request(req_t rq, logic fixed, resp_t known);
        resp_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= rq.op;
        entry_id <= rq.id;
        init_up <= rq.up;
        init_down <= rq.down;
        do
            @(posedge clk);
        while (in_stall);
        r = queue_apply(rq);
        if (fixed && r != known)
        begin
            $error("table row disagrees with queue behavior: %h vs %h", known, r);
            errors++;
        end
        pending_results.push_back(r);
        accepted++;
        @(negedge clk);
    endtask

    function automatic req_t random_request();
        req_t rq;
        int   pick;
        int   live [$];
        rq.id = 16'($urandom);
        rq.up = 16'($urandom);
        rq.down = 16'($urandom);
        pick = $urandom_range(99);
        if ($urandom_range(3) == 0)
        begin
            rq.up = 16'($urandom_range(8));
            rq.down = 16'($urandom_range(8));
        end
        for (int i = 0; i < CAPACITY; i++)
            if (q_live[i])
                live.push_back(i);
        if ($urandom_range(1))
            rq.id = 16'($urandom_range(15));
        if (pick < 35)
            rq.op = OP_ENQ;
        else if (pick < 60)
            rq.op = OP_DEQ;
        else
        begin
            rq.op = (pick < 80) ? OP_UP : OP_DOWN;
            if (live.size() > 0 && $urandom_range(9) != 0)
                rq.id = q_id[live[$urandom_range(live.size() - 1)]];
        end
        return rq;
    endfunction

    function automatic row_t mk(op_t o, logic [15:0] i, logic [15:0] u, logic [15:0] d,
                                logic f, status_t s, logic [15:0] ri, logic [15:0] ru,
                                logic [15:0] rd);
        row_t w;
        w.rq = '{op: o, id: i, up: u, down: d};
        w.fixed = f;
        w.rs = '{st: s, id: ri, up: ru, down: rd};
        return w;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge clk)
        if (rst_n)
            out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        resp_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d id %h", status, out_id);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                checked++;
                if (status !== exp_r.st)
                begin
                    $error("status: expected %0d, got %0d", exp_r.st, status);
                    errors++;
                end
                if (out_id !== exp_r.id)
                begin
                    $error("out_id: expected %h, got %h", exp_r.id, out_id);
                    errors++;
                end
                if (out_up !== exp_r.up)
                begin
                    $error("out_up: expected %h, got %h", exp_r.up, out_up);
                    errors++;
                end
                if (out_down !== exp_r.down)
                begin
                    $error("out_down: expected %h, got %h", exp_r.down, out_down);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        hold_off = 1'b0;
        wait (accepted >= 700);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        errors = 0;
        cycles = 0;
        accepted = 0;
        checked = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        op = OP_ENQ;
        entry_id = '0;
        init_up = '0;
        init_down = '0;
        send_idle_pct = 17;
        recv_idle_pct = 76;
        for (int i = 0; i < CAPACITY; i++)
            q_live[i] = 1'b0;
        q_count = 0;
        q_next_stamp = '0;

        rows.push_back(mk(OP_DEQ, 16'h1234, 0, 0, 1, ST_EMPTY, 0, 0, 0));
        rows.push_back(mk(OP_UP, 16'h0007, 0, 0, 1, ST_NOTFOUND, 0, 0, 0));
        rows.push_back(mk(OP_DOWN, 16'hFFFF, 0, 0, 1, ST_NOTFOUND, 0, 0, 0));
        rows.push_back(mk(OP_ENQ, 16'hFFFF, 16'hFFFF, 16'h0000, 1, ST_OK, 0, 0, 0));
        rows.push_back(mk(OP_UP, 16'hFFFF, 0, 0, 1, ST_OK, 0, 0, 0));
        rows.push_back(mk(OP_DEQ, 0, 0, 0, 1, ST_OK, 16'hFFFF, 16'hFFFF, 16'h0000));
        rows.push_back(mk(OP_ENQ, 16'h0000, 16'h0000, 16'hFFFF, 1, ST_OK, 0, 0, 0));
        rows.push_back(mk(OP_DOWN, 16'h0000, 0, 0, 1, ST_OK, 0, 0, 0));
        rows.push_back(mk(OP_ENQ, 16'h0000, 16'h0005, 16'h0005, 1, ST_OK, 0, 0, 0));
        rows.push_back(mk(OP_ENQ, 16'hAAAA, 16'h0005, 16'h0005, 1, ST_OK, 0, 0, 0));
        rows.push_back(mk(OP_UP, 16'h0000, 0, 0, 1, ST_OK, 0, 0, 0));
        rows.push_back(mk(OP_DEQ, 0, 0, 0, 0, ST_OK, 0, 0, 0));
        rows.push_back(mk(OP_DEQ, 0, 0, 0, 0, ST_OK, 0, 0, 0));
        rows.push_back(mk(OP_DEQ, 0, 0, 0, 1, ST_OK, 16'h0000, 16'h0001, 16'hFFFF));
        rows.push_back(mk(OP_DEQ, 0, 0, 0, 1, ST_EMPTY, 0, 0, 0));
        for (int i = 0; i < CAPACITY; i++)
            rows.push_back(mk(OP_ENQ, 16'h5555 ^ i[15:0], i[15:0], 16'h8000, 1,
                              ST_OK, 0, 0, 0));
        rows.push_back(mk(OP_ENQ, 16'h0001, 16'h0001, 16'h0001, 1, ST_FULL, 0, 0, 0));
        for (int i = 0; i < CAPACITY; i++)
            rows.push_back(mk(OP_DEQ, 0, 0, 0, 0, ST_OK, 0, 0, 0));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[n])
            send_request(rows[n].rq, rows[n].fixed, rows[n].rs);

        for (int n = 0; n < 1800; n++)
        begin
            if (n == 600)
            begin
                send_idle_pct = 76;
                recv_idle_pct = 17;
            end
            if (n == 1200)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_request(random_request(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (2 * CAPACITY + 10) @(posedge clk);

        $display("Covered %0d requests with %0d results checked,", accepted, checked);
        $display("including full, empty, unknown-id, saturation and tie cases.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
